FILE: hdl/chained_hash_dictionary_macros.svh
// Assertion macros for the chained hash dictionary.
// Included by RTL files that carry concurrent checks; no other dependencies.
`ifndef CHAINED_HASH_DICTIONARY_MACROS_SVH
`define CHAINED_HASH_DICTIONARY_MACROS_SVH
`ifndef SYNTHESIS
// Clocked check, disabled while reset is asserted.
`define CHD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked check that also holds during reset.
`define CHD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CHD_ASSERT(lbl, clk, rst_n, prop, msg)
`define CHD_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

FILE: hdl/chd_pkg.sv
// Shared types, field widths and operation/status codes of the chained hash dictionary.
// No dependencies.
package chd_pkg;
    localparam int BUCKETS_DEF    = 16;
    localparam int POOL_NODES_DEF = 64;
    localparam int KIND_W         = 2;
    localparam int KEY_W          = 32;
    localparam int VALUE_W        = 32;
    localparam int STATUS_W       = 2;

    typedef logic [KIND_W-1:0]          t_kind;
    typedef logic [KEY_W-1:0]           t_key;
    typedef logic signed [VALUE_W-1:0]  t_value;
    typedef logic [STATUS_W-1:0]        t_status;

    localparam t_kind KIND_INSERT = 2'd0;
    localparam t_kind KIND_FIND   = 2'd1;
    localparam t_kind KIND_REMOVE = 2'd2;
    localparam t_kind KIND_UNUSED = 2'd3;

    localparam t_status ST_OK        = 2'd0;
    localparam t_status ST_NOT_FOUND = 2'd1;
    localparam t_status ST_FULL      = 2'd2;

    localparam t_value NOT_FOUND_VALUE = -32'sd1;
endpackage

FILE: hdl/chd_if.sv
// Request and response channel interfaces of the chained hash dictionary.
// Depends on chd_pkg.
interface chd_req_if;
    import chd_pkg::*;
    logic   valid;
    logic   ready;
    t_kind  kind;
    t_key   key;
    t_value value;
    modport source (output valid, output kind, output key, output value, input ready);
    modport sink   (input valid, input kind, input key, input value, output ready);
endinterface

interface chd_rsp_if;
    import chd_pkg::*;
    logic    valid;
    logic    ready;
    t_status status;
    t_value  found_value;
    modport source (output valid, output status, output found_value, input ready);
    modport sink   (input valid, input status, input found_value, output ready);
endinterface

FILE: hdl/chd_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module chd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: hdl/chd_mod.sv
// Byte-serial key modulo bucket count by reciprocal multiplication: one key byte per cycle.
// Depends on chd_pkg.
module chd_mod #(
    parameter int BUCKETS = chd_pkg::BUCKETS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  chd_pkg::t_key              i_key,
    output logic                       o_done,
    output logic [$clog2(BUCKETS)-1:0] o_rem
);
    import chd_pkg::*;
    localparam int BW    = $clog2(BUCKETS);
    localparam int STEPS = KEY_W / 8;
    localparam int CW    = $clog2(STEPS);
    localparam int XW    = BW + 8;
    localparam int SH    = XW + BW;
    localparam int MW    = XW + 1;
    localparam logic [MW-1:0] RECIP =
        MW'(((64'd1 << SH) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS));
    localparam logic [XW-1:0] DIVISOR = XW'(BUCKETS);

    logic                  r_busy, n_busy;
    logic                  r_done, n_done;
    logic [CW-1:0]         r_cnt, n_cnt;
    t_key                  r_sh, n_sh;
    logic [BW-1:0]         r_rem, n_rem;
    logic [XW-1:0]         w_x;
    logic [XW+MW-1:0]      w_prod;
    logic [XW+MW-SH-1:0]   w_q;
    logic [XW-1:0]         w_qb;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_sh   = r_sh;
        n_rem  = r_rem;
        // The partial remainder joined with the next byte stays below 256 times the
        // divisor, so the rounded-up reciprocal gives the exact quotient.
        w_x    = {r_rem, r_sh[KEY_W-1 -: 8]};
        w_prod = {{MW{1'b0}}, w_x} * {{XW{1'b0}}, RECIP};
        w_q    = w_prod[XW+MW-1:SH];
        w_qb   = XW'(w_q * DIVISOR);
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_sh   = i_key;
            n_rem  = '0;
        end else if (r_busy) begin
            n_rem = BW'(w_x - w_qb);
            n_sh  = r_sh << 8;
            n_cnt = r_cnt + CW'(1);
            if (r_cnt == CW'(STEPS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_sh  <= n_sh;
        r_rem <= n_rem;
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;
endmodule

FILE: hdl/chained_hash_dictionary.sv
// Top level of the chained hash dictionary: request sequencer, node pool and bucket table.
// Depends on chd_pkg, chd_if, chd_ram, chd_mod and chained_hash_dictionary_macros.svh.
//
//  channel  | dir | beat contents
//  ---------+-----+----------------------------
//  i_req    | in  | kind, key, value
//  o_rsp    | out | status, found_value
//
// A request passes through acceptance, the byte-serial bucket modulo, a bucket read and the
// loading of o_rsp; insert adds S_INS_B and S_INS_C, find walks the chain node by node (up to
// POOL_NODES nodes), and remove walks it likewise and unlinks in S_REM_A, plus S_REM_B past the head.
// After reset a clearing pass over every bucket empties the bucket table; i_req.ready stays low.
// One request is in work at a time; the next is taken while a response waits in o_rsp.
// A waiting response holds its beat until o_rsp.ready, and a finished request waits behind it.
`include "chained_hash_dictionary_macros.svh"
module chained_hash_dictionary #(
    parameter int BUCKETS    = chd_pkg::BUCKETS_DEF,
    parameter int POOL_NODES = chd_pkg::POOL_NODES_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    chd_req_if.sink   i_req,
    chd_rsp_if.source o_rsp
);
    import chd_pkg::*;
    localparam int BW = $clog2(BUCKETS);
    localparam int NW = $clog2(POOL_NODES);
    localparam int LW = $clog2(POOL_NODES + 1);
    localparam logic [LW-1:0] NIL = LW'(POOL_NODES);

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_MOD   = 4'd2;
    localparam logic [3:0] S_BRD   = 4'd3;
    localparam logic [3:0] S_INS_B = 4'd4;
    localparam logic [3:0] S_INS_C = 4'd5;
    localparam logic [3:0] S_WCMP  = 4'd6;
    localparam logic [3:0] S_REM_A = 4'd7;
    localparam logic [3:0] S_REM_B = 4'd8;
    localparam logic [3:0] S_DONE  = 4'd9;

    logic [3:0]    r_state, n_state;
    logic [BW-1:0] r_clr, n_clr;
    t_kind         r_kind, n_kind;
    t_key          r_key, n_key;
    t_value        r_value, n_value;
    logic [BW-1:0] r_bkt, n_bkt;
    logic [LW-1:0] r_head, n_head;
    logic [LW-1:0] r_tail, n_tail;
    logic [LW-1:0] r_free, n_free;
    logic [LW-1:0] r_fresh, n_fresh;
    logic [LW-1:0] r_node, n_node;
    logic [LW-1:0] r_prev, n_prev;
    logic [LW-1:0] r_nxt, n_nxt;
    logic [LW-1:0] r_steps, n_steps;
    logic          r_from_ram, n_from_ram;
    t_status       r_status, n_status;
    t_value        r_found, n_found;
    logic          r_out_valid, n_out_valid;
    t_status       r_out_status, n_out_status;
    t_value        r_out_value, n_out_value;

    logic              w_accept;
    logic              w_mod_done;
    logic [BW-1:0]     w_mod_rem;
    logic              bk_we;
    logic [BW-1:0]     bk_waddr;
    logic [2*LW-1:0]   bk_wdata, bk_rdata;
    logic [LW-1:0]     bk_head, bk_tail;
    logic              kd_we;
    logic [2*KEY_W-1:0] kd_rdata;
    logic              lk_we;
    logic [NW-1:0]     lk_waddr;
    logic [LW-1:0]     lk_wdata, lk_rdata;
    logic [NW-1:0]     w_rd_addr;
    logic [LW-1:0]     w_steps_inc;

    assign w_accept = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE);
    assign bk_head = bk_rdata[2*LW-1:LW];
    assign bk_tail = bk_rdata[LW-1:0];
    assign w_steps_inc = r_steps + LW'(1);

    chd_mod #(.BUCKETS(BUCKETS)) u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_accept),
        .i_key   (i_req.key),
        .o_done  (w_mod_done),
        .o_rem   (w_mod_rem)
    );

    chd_ram #(.WIDTH(2*LW), .DEPTH(BUCKETS)) u_bucket_ram (
        .i_clk   (i_clk),
        .i_we    (bk_we),
        .i_waddr (bk_waddr),
        .i_wdata (bk_wdata),
        .i_raddr (w_mod_rem),
        .o_rdata (bk_rdata)
    );

    chd_ram #(.WIDTH(2*KEY_W), .DEPTH(POOL_NODES)) u_kd_ram (
        .i_clk   (i_clk),
        .i_we    (kd_we),
        .i_waddr (r_node[NW-1:0]),
        .i_wdata ({r_key, r_value}),
        .i_raddr (w_rd_addr),
        .o_rdata (kd_rdata)
    );

    chd_ram #(.WIDTH(LW), .DEPTH(POOL_NODES)) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (lk_we),
        .i_waddr (lk_waddr),
        .i_wdata (lk_wdata),
        .i_raddr (w_rd_addr),
        .o_rdata (lk_rdata)
    );

    always_comb begin
        n_state      = r_state;
        n_clr        = r_clr;
        n_kind       = r_kind;
        n_key        = r_key;
        n_value      = r_value;
        n_bkt        = r_bkt;
        n_head       = r_head;
        n_tail       = r_tail;
        n_free       = r_free;
        n_fresh      = r_fresh;
        n_node       = r_node;
        n_prev       = r_prev;
        n_nxt        = r_nxt;
        n_steps      = r_steps;
        n_from_ram   = r_from_ram;
        n_status     = r_status;
        n_found      = r_found;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_out_status = r_out_status;
        n_out_value  = r_out_value;
        bk_we        = 1'b0;
        bk_waddr     = r_bkt;
        bk_wdata     = {r_head, r_tail};
        kd_we        = 1'b0;
        lk_we        = 1'b0;
        lk_waddr     = r_node[NW-1:0];
        lk_wdata     = NIL;
        w_rd_addr    = '0;

        unique case (r_state)
            S_CLEAR: begin
                bk_we    = 1'b1;
                bk_waddr = r_clr;
                bk_wdata = {NIL, NIL};
                n_clr    = r_clr + BW'(1);
                if (r_clr == BW'(BUCKETS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_kind   = i_req.kind;
                    n_key    = i_req.key;
                    n_value  = i_req.value;
                    n_status = ST_OK;
                    n_found  = NOT_FOUND_VALUE;
                    n_state  = S_MOD;
                end
            end
            S_MOD: begin
                // The bucket read address follows the modulo result directly.
                if (w_mod_done) begin
                    n_bkt   = w_mod_rem;
                    n_state = S_BRD;
                end
            end
            S_BRD: begin
                n_head  = bk_head;
                n_tail  = bk_tail;
                n_prev  = NIL;
                n_steps = '0;
                priority if (r_kind == KIND_INSERT) begin
                    if (r_free == NIL) begin
                        n_status = ST_FULL;
                        n_state  = S_DONE;
                    end else begin
                        n_node = r_free;
                        // Nodes at or above the fill mark were never used; the free list runs on
                        // to their successor without a link read.
                        if (r_free >= r_fresh) begin
                            n_free     = r_free + LW'(1);
                            n_fresh    = r_free + LW'(1);
                            n_from_ram = 1'b0;
                        end else begin
                            w_rd_addr  = r_free[NW-1:0];
                            n_from_ram = 1'b1;
                        end
                        n_state = S_INS_B;
                    end
                end else if (r_kind == KIND_FIND || r_kind == KIND_REMOVE) begin
                    if (bk_head == NIL) begin
                        n_status = ST_NOT_FOUND;
                        n_state  = S_DONE;
                    end else begin
                        w_rd_addr = bk_head[NW-1:0];
                        n_node    = bk_head;
                        n_state   = S_WCMP;
                    end
                end else begin
                    n_state = S_DONE;
                end
            end
            S_INS_B: begin
                if (r_from_ram) begin
                    n_free = lk_rdata;
                end
                kd_we    = 1'b1;
                lk_we    = 1'b1;
                lk_waddr = r_node[NW-1:0];
                lk_wdata = NIL;
                n_state  = S_INS_C;
            end
            S_INS_C: begin
                if (r_tail != NIL) begin
                    lk_we    = 1'b1;
                    lk_waddr = r_tail[NW-1:0];
                    lk_wdata = r_node;
                end
                bk_we    = 1'b1;
                bk_wdata = {((r_head == NIL) ? r_node : r_head), r_node};
                n_state  = S_DONE;
            end
            S_WCMP: begin
                if (kd_rdata[2*KEY_W-1:KEY_W] == r_key) begin
                    if (r_kind == KIND_FIND) begin
                        n_found = $signed(kd_rdata[VALUE_W-1:0]);
                        n_state = S_DONE;
                    end else begin
                        n_nxt   = lk_rdata;
                        n_state = S_REM_A;
                    end
                end else if (lk_rdata == NIL || w_steps_inc == NIL) begin
                    n_status = ST_NOT_FOUND;
                    n_state  = S_DONE;
                end else begin
                    // Next node's read goes out while this one is compared.
                    w_rd_addr = lk_rdata[NW-1:0];
                    n_prev    = r_node;
                    n_node    = lk_rdata;
                    n_steps   = w_steps_inc;
                end
            end
            S_REM_A: begin
                lk_we    = 1'b1;
                lk_waddr = r_node[NW-1:0];
                lk_wdata = r_free;
                n_free   = r_node;
                bk_we    = 1'b1;
                bk_wdata = {((r_prev == NIL) ? r_nxt : r_head),
                            ((r_tail == r_node) ? r_prev : r_tail)};
                n_state  = (r_prev == NIL) ? S_DONE : S_REM_B;
            end
            S_REM_B: begin
                lk_we    = 1'b1;
                lk_waddr = r_prev[NW-1:0];
                lk_wdata = r_nxt;
                n_state  = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_value  = r_found;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_free      <= '0;
            r_fresh     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_free      <= n_free;
            r_fresh     <= n_fresh;
            r_out_valid <= n_out_valid;
        end
        r_kind       <= n_kind;
        r_key        <= n_key;
        r_value      <= n_value;
        r_bkt        <= n_bkt;
        r_head       <= n_head;
        r_tail       <= n_tail;
        r_node       <= n_node;
        r_prev       <= n_prev;
        r_nxt        <= n_nxt;
        r_steps      <= n_steps;
        r_from_ram   <= n_from_ram;
        r_status     <= n_status;
        r_found      <= n_found;
        r_out_status <= n_out_status;
        r_out_value  <= n_out_value;
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_out_status;
    assign o_rsp.found_value = r_out_value;

    `CHD_ASSERT(a_fresh_bound, i_clk, i_rst_n, r_fresh <= NIL, "fill mark beyond pool")
    `CHD_ASSERT(a_free_fresh, i_clk, i_rst_n, r_free <= r_fresh, "free head past fill mark")
    `CHD_ASSERT(a_accept_mod, i_clk, i_rst_n, w_accept |=> (r_state == S_MOD), "no modulo")
    `CHD_ASSERT(a_mod_done, i_clk, i_rst_n, w_mod_done |-> (r_state == S_MOD), "stray done")
endmodule
